// File: rtl/core/peqs_pkg.sv
// Shared constants and types for the priority event queue scheduler.
package peqs_pkg;
  localparam int NumObjectsDefault = 64;
  localparam int QueueDepthDefault = 8;
  localparam int RowCountDefault   = 8;
  localparam int SigW   = 16;
  localparam int ParW   = 32;
  localparam int EventW = SigW + ParW;
  localparam int ObjW   = 6;
  localparam int LimW   = 4;
  localparam logic [LimW-1:0] LimitReset = 4'd8;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_IDLE = 2'd2
  } status_t;

  localparam logic OP_POST     = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // Index of the lowest set bit of a byte, zero when none is set.
  function automatic logic [2:0] lowest_bit(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction
endpackage

// File: rtl/core/priority_event_queue_scheduler.sv
// Top level of the priority event queue scheduler.
//   channel | dir | handshake              | payload
//   s_axis  | in  | s_axis_tvalid/tready   | tdata: opcode, object_index, to_front, signal, param
//   m_axis  | out | m_axis_tvalid/tready   | tdata: status, event_valid, object, signal, param
//   cfg     | in  | cfg_we                 | cfg_wdata: queue_limit
// A post passes through pointer read and update with slot write to its result; a dispatch
// passes through pointer read, update with slot address, slot read and result capture.
// s_axis_tready stays low until the result beat has left, so no new post or dispatch is
// taken before the last one is through; a stall on m_axis holds input off.
// Pointers and counts live in a synchronous memory with one valid bit per object, and
// event slots in another; reset clears the valid bits and the ready bitmap at once.
module priority_event_queue_scheduler import peqs_pkg::*; #(
  parameter int NumObjects = NumObjectsDefault,
  parameter int QueueDepth = QueueDepthDefault,
  parameter int RowCount   = RowCountDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // opcode[0], object_index[6:1], to_front[7], event_signal[23:8], event_param[55:24]
  input  logic [55:0]     s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // status[1:0], event_valid[2], out_object[8:3], out_signal[24:9], out_param[56:25]
  output logic [63:0]     m_axis_tdata,
  input  logic            cfg_we,
  input  logic [LimW-1:0] cfg_wdata
);
  localparam int SlotW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW   = $clog2(QueueDepth + 1);
  localparam int StoreD = NumObjects * QueueDepth;
  localparam int AddrW  = (StoreD > 1) ? $clog2(StoreD) : 1;
  localparam int OIdxW  = (NumObjects > 1) ? $clog2(NumObjects) : 1;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_CAPTURE} state_t;

  typedef struct packed {
    logic [CntW-1:0]  count;
    logic [SlotW-1:0] tail;
    logic [SlotW-1:0] head;
  } ptr_t;

  state_t state;
  logic [LimW-1:0] queue_limit;
  logic [7:0] ready_group;
  logic [7:0] ready_rows [8];

  ptr_t ptr_mem [NumObjects];
  logic [NumObjects-1:0] ptr_valid;
  ptr_t ptr_rdata;
  logic ptr_rvalid;
  logic ptr_we;
  logic [OIdxW-1:0] ptr_raddr;

  logic [AddrW-1:0] waddr, raddr;
  logic [EventW-1:0] wdata, rdata;
  logic we;

  logic              cur_op, cur_front;
  logic [5:0]        cur_obj;
  logic [EventW-1:0] cur_ev;

  // Effective limit, clipped to the queue depth.
  logic [CntW:0] limit;
  always_comb begin
    if ({{(CntW+1){1'b0}}, queue_limit} > (CntW+1+LimW)'(QueueDepth)) begin
      limit = (CntW+1)'(QueueDepth);
    end else begin
      limit = (CntW+1)'(queue_limit);
    end
  end

  logic in_fire;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  logic       op, front;
  logic [5:0] obj;
  logic [EventW-1:0] ev_in;
  assign op    = s_axis_tdata[0];
  assign obj   = s_axis_tdata[6:1];
  assign front = s_axis_tdata[7];
  assign ev_in = {s_axis_tdata[23:8], s_axis_tdata[55:24]};

  logic [OIdxW-1:0] oi;
  assign oi = OIdxW'(obj);

  // Dispatch target from the bitmap.
  logic [2:0] gy, rx;
  logic [7:0] rbits;
  logic [5:0] dobj;
  logic [OIdxW-1:0] di;
  assign gy    = lowest_bit(ready_group);
  assign rbits = ready_rows[gy];
  assign rx    = lowest_bit(rbits);
  assign dobj  = {gy, rx};
  assign di    = OIdxW'(dobj);

  assign ptr_raddr = (op == OP_POST) ? oi : di;

  // The bitmap does not change between acceptance and update, so gy and rx still name
  // the dispatch target while the operation executes.
  logic [2:0] cur_row, cur_col;
  logic [OIdxW-1:0] ti;
  ptr_t cur, nxt;
  assign cur_row = cur_obj[5:3];
  assign cur_col = cur_obj[2:0];
  assign ti      = OIdxW'(cur_obj);
  assign cur     = ptr_rvalid ? ptr_rdata : '0;

  logic post_ok, disp_ok;
  assign post_ok = (cur_op == OP_POST) && (7'(cur_obj) < 7'(NumObjects)) &&
                   (4'(cur_row) < 4'(RowCount)) && ((CntW+1)'(cur.count) < limit);
  assign disp_ok = (cur_op == OP_DISPATCH) && (ready_group != 8'd0) && (rbits != 8'd0) &&
                   (7'(cur_obj) < 7'(NumObjects)) && (cur.count != '0);

  logic [CntW:0] head_ext, tail_ext;
  assign head_ext = (CntW+1)'(cur.head);
  assign tail_ext = (CntW+1)'(cur.tail);

  logic [SlotW-1:0] slot;
  logic [AddrW-1:0] saddr;
  always_comb begin
    nxt  = cur;
    slot = cur.head;
    if (cur_op == OP_POST) begin
      if (!cur_front) begin
        slot     = cur.tail;
        nxt.tail = (tail_ext + 1'b1 >= limit) ? '0 : SlotW'(tail_ext + 1'b1);
      end else begin
        // Step the head back, wrapping against the limit.
        slot     = SlotW'(((head_ext == '0) ? limit : head_ext) - 1'b1);
        nxt.head = slot;
      end
      nxt.count = cur.count + CntW'(1);
    end else begin
      nxt.head  = (head_ext + 1'b1 >= limit) ? '0 : SlotW'(head_ext + 1'b1);
      nxt.count = cur.count - CntW'(1);
    end
  end
  assign saddr  = AddrW'(ti * QueueDepth) + AddrW'(slot);
  assign ptr_we = (state == S_EXEC) && (post_ok || disp_ok);

  logic [7:0] row_after;
  assign row_after = rbits & ~(8'd1 << rx);

  always_ff @(posedge clk) begin
    if (ptr_we) ptr_mem[ti] <= nxt;
    if (in_fire) ptr_rdata <= ptr_mem[ptr_raddr];
  end

  peqs_store #(.Depth(StoreD)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      queue_limit   <= LimitReset;
      ready_group   <= '0;
      m_axis_tvalid <= 1'b0;
      we            <= 1'b0;
      ptr_valid     <= '0;
      ptr_rvalid    <= 1'b0;
      for (int i = 0; i < 8; i++) ready_rows[i] <= '0;
    end else begin
      we <= 1'b0;
      if (cfg_we) queue_limit <= cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state      <= S_EXEC;
            cur_op     <= op;
            cur_obj    <= (op == OP_POST) ? obj : dobj;
            cur_front  <= front;
            cur_ev     <= ev_in;
            ptr_rvalid <= ptr_valid[ptr_raddr];
          end
        end
        S_EXEC: begin
          if (cur_op == OP_POST) begin
            state         <= S_IDLE;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {62'd0, post_ok ? ST_OK : ST_FULL};
            if (post_ok) begin
              ptr_valid[ti] <= 1'b1;
              we            <= 1'b1;
              waddr         <= saddr;
              wdata         <= cur_ev;
              if (cur.count == '0) begin
                ready_group[cur_row]         <= 1'b1;
                ready_rows[cur_row][cur_col] <= 1'b1;
              end
            end
          end else if (disp_ok) begin
            state <= S_READ;
            raddr <= saddr;
            if (cur.count == CntW'(1)) begin
              ready_rows[gy] <= row_after;
              if (row_after == 8'd0) ready_group[gy] <= 1'b0;
            end
          end else begin
            state         <= S_IDLE;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {62'd0, ST_IDLE};
          end
        end
        S_READ: state <= S_CAPTURE;
        S_CAPTURE: begin
          state         <= S_IDLE;
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= {7'd0, rdata[ParW-1:0], rdata[EventW-1:ParW], cur_obj,
                            1'b1, ST_OK};
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/peqs_store.sv
// Event slot memory: one write port, one registered read port.
module peqs_store import peqs_pkg::*; #(
  parameter int Depth = NumObjectsDefault * QueueDepthDefault
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [EventW-1:0]        wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [EventW-1:0]        rdata
);
  logic [EventW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/peqs_checker.sv
// Port-level checks for the scheduler, bound to the top level.
module peqs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  // A result that is not yet taken holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Input is not taken while a result waits.
  a_one: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken with result pending");

  // A delivered event always reports success.
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == 2'd0)
    else $error("event delivered with failure status");

  // Status never uses the unassigned code.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("bad status code");
endmodule

bind priority_event_queue_scheduler peqs_checker u_peqs_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// File: test/testbench.sv
// Randomized and directed test of the priority event queue scheduler against its own predictor.
module testbench;
  import peqs_pkg::*;

  typedef struct {
    status_t     st;
    bit          valid;
    bit [5:0]    obj;
    bit [15:0]   sig;
    bit [31:0]   par;
  } sched_result_t;

  // Mirrors the per-object queues and the ready bitmap, and holds the results still owed.
  class sched_scoreboard;
    int            limit_reg = LimitReset;
    int            head[64];
    int            tail[64];
    int            count[64];
    bit [47:0]     slots[64][8];
    bit [7:0]      group_bits;
    bit [7:0]      row_bits[8];
    sched_result_t owed[$];
    int            mismatches, results, posts, dispatches, refused, idle_hits, delivered;

    function int first_set(bit [7:0] v);
      for (int i = 0; i < 8; i++) if (v[i]) return i;
      return 0;
    endfunction

    function int queued();
      int n;
      n = 0;
      foreach (count[i]) n += count[i];
      return n;
    endfunction

    function void note_beat(logic [55:0] d);
      sched_result_t r;
      int lim, o, y, x;
      bit [7:0] rb;
      lim = (limit_reg > 8) ? 8 : limit_reg;
      r = '{ST_OK, 1'b0, 6'd0, 16'd0, 32'd0};
      if (d[0] == OP_POST) begin
        posts++;
        o = d[6:1];
        if (count[o] >= lim) begin
          r.st = ST_FULL;
          refused++;
        end else begin
          if (!d[7]) begin
            slots[o][tail[o] % 8] = {d[23:8], d[55:24]};
            tail[o]++;
            if (tail[o] >= lim) tail[o] = 0;
          end else begin
            if (head[o] == 0) head[o] = lim;
            head[o]--;
            slots[o][head[o] % 8] = {d[23:8], d[55:24]};
          end
          count[o]++;
          if (count[o] == 1) begin
            group_bits[o / 8] = 1'b1;
            row_bits[o / 8][o % 8] = 1'b1;
          end
        end
      end else begin
        dispatches++;
        r.st = ST_IDLE;
        if (group_bits != 0) begin
          y = first_set(group_bits);
          rb = row_bits[y];
          x = first_set(rb);
          o = y * 8 + x;
          if (rb != 0 && count[o] != 0) begin
            count[o]--;
            if (count[o] == 0) begin
              row_bits[y][x] = 1'b0;
              if (row_bits[y] == 0) group_bits[y] = 1'b0;
            end
            r.st = ST_OK;
            r.valid = 1'b1;
            r.obj = o[5:0];
            r.sig = slots[o][head[o] % 8][47:32];
            r.par = slots[o][head[o] % 8][31:0];
            head[o]++;
            if (head[o] >= lim) head[o] = 0;
            delivered++;
          end
        end
        if (r.st == ST_IDLE) idle_hits++;
      end
      owed.push_back(r);
    endfunction

    function void check_beat(logic [63:0] d);
      sched_result_t e;
      results++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", d);
        return;
      end
      e = owed.pop_front();
      if (d[1:0] !== e.st || d[2] !== e.valid || d[8:3] !== e.obj || d[24:9] !== e.sig ||
          d[56:25] !== e.par || d[63:57] !== 7'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected st=%0d v=%0d obj=%0d sig=%h par=%h, got %h",
                   results, e.st, e.valid, e.obj, e.sig, e.par, d);
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [55:0]     s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [63:0]     m_axis_tdata;
  logic            cfg_we;
  logic [LimW-1:0] cfg_wdata;

  sched_scoreboard sb;
  bit              calm;
  bit              hold_req;
  int              hold_left;
  int              hot[4];

  priority_event_queue_scheduler dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
  end

  task automatic send_beat(input logic [55:0] d);
    if (!calm && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_beat(d);
  endtask

  task automatic post(input int o, input bit front, input bit [15:0] sig, input bit [31:0] par);
    send_beat({par, sig, front, o[5:0], OP_POST});
  endtask

  // Fields other than the opcode are ignored on a dispatch; fill them with noise.
  task automatic dispatch();
    send_beat({$urandom(), 16'($urandom()), 7'($urandom()), OP_DISPATCH});
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Queues are emptied first so that no dispatch ever reads a slot that was never written.
  task automatic set_limit(input int v);
    while (sb.queued() != 0) dispatch();
    dispatch();
    wait_quiet();
    cfg_wdata <= v[LimW-1:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.limit_reg = v;
  endtask

  task automatic random_item();
    int o;
    if ($urandom_range(99) < 55) begin
      o = ($urandom_range(2) == 0) ? $urandom_range(63) : hot[$urandom_range(3)];
      post(o, $urandom_range(3) == 0, 16'($urandom()), $urandom());
    end else begin
      dispatch();
    end
  endtask

  initial begin
    int limits[7] = '{8, 1, 3, 8, 5, 2, 7};
    int guard;
    sb = new();
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= LimitReset;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle dispatch, extreme objects and fields, both ends, a full queue.
    dispatch();
    post(63, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
    post(0, 1'b0, 16'h0000, 32'h0000_0000);
    post(0, 1'b1, 16'hA5A5, 32'h5A5A_5A5A);
    post(9, 1'b0, 16'h1234, 32'h89AB_CDEF);
    repeat (5) dispatch();
    set_limit(2);
    post(5, 1'b0, 16'h0001, 32'h1);
    post(5, 1'b1, 16'h0002, 32'h2);
    post(5, 1'b0, 16'h0003, 32'h3);
    post(5, 1'b1, 16'h0004, 32'h4);
    post(40, 1'b1, 16'h0005, 32'h5);
    repeat (4) dispatch();

    for (int p = 0; p < 7; p++) begin
      set_limit(limits[p]);
      foreach (hot[i]) hot[i] = $urandom_range(63);
      calm = (p == 1);
      if (p == 2) hold_req = 1'b1;
      repeat (200) random_item();
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (sb.owed.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.owed.size() != 0) begin
      $display("%0d results never arrived", sb.owed.size());
      $display("RESULT: ERROR");
      $finish;
    end
    repeat (20) @(posedge clk);
    $display("Sent %0d posts (%0d refused) and %0d dispatches (%0d delivered, %0d idle),",
             sb.posts, sb.refused, sb.dispatches, sb.delivered, sb.idle_hits);
    $display("over several queue limits between 1 and 8; %0d results checked, %0d mismatches.",
             sb.results, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
